// File: hw/rtl/mws_pkg.sv
// shared types and constants of the minimum window subsequence search
// no dependencies
`default_nettype none
package mws_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65536;
  localparam int CELL_IDX_W  = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 5;
  localparam int START_W     = 16;
  localparam int POS_W       = 17;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic [7:0] text_char;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] best_start;
    logic [POS_W-1:0]   best_length;
    logic               overflow;
  } out_item_t;

  // state handed from one prefix cell to the next
  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] start;
  } link_t;

  // update made by a cell on the current byte
  typedef struct packed {
    logic               hit;
    logic [START_W-1:0] start;
  } hit_t;

endpackage
`default_nettype wire

// File: hw/rtl/min_window_subsequence.sv
// minimum window subsequence search, top level: prefix cell chain,
// best window tracker and result register; depends on mws_pkg, mws_cell, mws_best
// latency: the result of the last-marked item is valid the cycle after it is accepted
// throughput: one text item per cycle unless a last item is stalled by a held result, as all cells update together
// reset: synchronous, empties all cells, zeroes counters and best window,
// pattern length back to one with all pattern characters zero
`default_nettype none
module min_window_subsequence import mws_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 text_valid,
  output logic                      text_stall,
  input  wire in_item_t             text_item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_item_t                 result_item,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(MAX_TEXT);

  // configuration registers
  logic [LEN_W-1:0] pattern_length;
  logic [CFG_W-1:0] pattern_low_chars;
  logic [CFG_W-1:0] pattern_high_chars;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LEN_W'(1);
      pattern_low_chars  <= '0;
      pattern_high_chars <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_low_chars  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  // length in use: zero counts as one, saturate at the cell count
  logic [LEN_W-1:0]      used_len;
  logic [CELL_IDX_W-1:0] last_cell;

  always_comb begin
    if (pattern_length == '0) begin
      used_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      used_len = LEN_W'(MAX_PATTERN);
    end else begin
      used_len = pattern_length;
    end
  end

  assign last_cell = CELL_IDX_W'(used_len - LEN_W'(1));

  logic [2*CFG_W-1:0] pattern_chars;
  assign pattern_chars = {pattern_high_chars, pattern_low_chars};

  // handshake: only a last item needs the result register free
  logic accept;
  logic done;
  logic take;
  logic in_range;

  assign text_stall = result_valid && result_stall && text_item.text_last;
  assign accept     = text_valid && !text_stall;
  assign done       = accept && text_item.text_last;

  // text position and overflow flag
  logic [POS_W-1:0] text_position;
  logic             overflow_flag;
  logic             overflow_next;

  assign in_range      = (text_position < TEXT_LIMIT);
  assign take          = accept && in_range;
  assign overflow_next = overflow_flag || (accept && !in_range);

  always_ff @(posedge clk) begin
    if (rst || done) begin
      text_position <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (take) begin
        text_position <= text_position + POS_W'(1);
      end
      overflow_flag <= overflow_next;
    end
  end

  // cell chain: cell 0 sees an always-valid neighbor starting at this position,
  // every cell reads its neighbor's old value so all update in the same cycle
  link_t links [MAX_PATTERN+1];
  hit_t  hits  [MAX_PATTERN];

  assign links[0].valid = 1'b1;
  assign links[0].start = text_position[START_W-1:0];

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    mws_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .take         (take),
      .clear        (done),
      .en           (LEN_W'(k) < used_len),
      .pattern_char (pattern_chars[8*k +: 8]),
      .text_char    (text_item.text_char),
      .prev         (links[k]),
      .cur          (links[k+1]),
      .upd          (hits[k])
    );
  end

  // the cell of the full pattern feeds the window tracker
  hit_t               win;
  logic               found_next;
  logic [START_W-1:0] start_next;
  logic [POS_W-1:0]   length_next;

  assign win = hits[last_cell];

  mws_best u_best (
    .clk         (clk),
    .rst         (rst),
    .clear       (done),
    .win         (win),
    .pos         (text_position[START_W-1:0]),
    .found_next  (found_next),
    .start_next  (start_next),
    .length_next (length_next)
  );

  // result register, loaded on the last item of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_item.found       <= found_next;
      result_item.best_start  <= found_next ? start_next : '0;
      result_item.best_length <= found_next ? length_next : '0;
      result_item.overflow    <= overflow_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mws_cell.sv
// one prefix cell: latest start of a partial match of its pattern prefix
// depends on mws_pkg
`default_nettype none
module mws_cell import mws_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic       clear,
  input  wire logic       en,
  input  wire logic [7:0] pattern_char,
  input  wire logic [7:0] text_char,
  input  wire link_t      prev,
  output link_t           cur,
  output hit_t            upd
);

  assign upd.hit   = take && en && (pattern_char == text_char) && prev.valid;
  assign upd.start = prev.start;

  // start is only read while valid is set, so it needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (clear) begin
      cur.valid <= 1'b0;
    end else if (upd.hit) begin
      cur.valid <= 1'b1;
    end
    if (upd.hit) begin
      cur.start <= prev.start;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mws_best.sv
// best window tracker: keeps the shortest complete match of the text
// depends on mws_pkg
`default_nettype none
module mws_best import mws_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               clear,
  input  wire hit_t               win,
  input  wire logic [START_W-1:0] pos,
  output logic                    found_next,
  output logic [START_W-1:0]      start_next,
  output logic [POS_W-1:0]        length_next
);

  logic [START_W-1:0] best_start;
  logic [POS_W-1:0]   best_length;
  logic [POS_W-1:0]   wlen;
  logic               better;

  assign wlen   = {1'b0, pos} - {1'b0, win.start} + POS_W'(1);
  assign better = win.hit && ((best_length == '0) || (wlen < best_length));

  assign start_next  = better ? win.start : best_start;
  assign length_next = better ? wlen : best_length;
  assign found_next  = (length_next != '0);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_start  <= '0;
      best_length <= '0;
    end else begin
      best_start  <= start_next;
      best_length <= length_next;
    end
  end

endmodule
`default_nettype wire

// File: tb/min_window_subsequence_tb.sv
`timescale 1ns / 1ps
// testbench of min_window_subsequence: directed, long-text, backpressure and random texts,
// each result checked against a window search predictor kept inside this module
// depends on mws_pkg and the min_window_subsequence rtl
module min_window_subsequence_tb;
  import mws_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 175;

  typedef logic [7:0] text_t [$];

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 text_valid;
  logic                 text_stall;
  in_item_t             text_item;
  logic                 result_valid;
  logic                 result_stall;
  out_item_t            result_item;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // pacing: percent chance of an idle burst before an item / on a result cycle
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          long_hold_go = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // predictor copy of the pattern registers
  logic [4:0]  pat_len_q;
  logic [63:0] chars_lo;
  logic [63:0] chars_hi;
  // predictor copy of the search state
  logic [START_W-1:0] win_start [MAX_PATTERN];
  bit                 win_valid [MAX_PATTERN];
  logic [POS_W-1:0]   byte_pos;
  logic [START_W-1:0] best_at;
  logic [POS_W-1:0]   best_len;
  bit                 text_ovf;
  // windows still owed by the block, oldest first
  out_item_t          expected_windows [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  min_window_subsequence dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("min_window_subsequence_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // length 0 acts as 1, anything past the cell count saturates
  function automatic int unsigned used_len();
    int unsigned n;
    n = pat_len_q;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic logic [7:0] char_at(int unsigned k);
    if (k < 8) return chars_lo[8*k +: 8];
    return chars_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_search();
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_valid[k] = 1'b0;
      win_start[k] = '0;
    end
    byte_pos = '0;
    best_at  = '0;
    best_len = '0;
    text_ovf = 1'b0;
  endfunction

  // one byte into the prefix cells; walking downward keeps each cell on
  // its neighbour's value from before this byte
  function automatic void absorb_byte(logic [7:0] c);
    int               n;
    logic [POS_W-1:0] wlen;
    n = used_len();
    for (int k = n - 1; k >= 0; k--) begin
      if (char_at(k) != c) continue;
      if (k == 0) begin
        win_start[0] = byte_pos[START_W-1:0];
        win_valid[0] = 1'b1;
      end else if (win_valid[k-1]) begin
        win_start[k] = win_start[k-1];
        win_valid[k] = 1'b1;
      end else begin
        continue;
      end
      // full pattern closed on this byte: strictly shorter wins, so ties keep the earliest
      if (k == n - 1) begin
        wlen = byte_pos - {1'b0, win_start[k]} + 1'b1;
        if (best_len == '0 || wlen < best_len) begin
          best_len = wlen;
          best_at  = win_start[k];
        end
      end
    end
    byte_pos = byte_pos + 1'b1;
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t r;
    // bytes past the text limit only raise the overflow flag
    if (byte_pos < MAX_TEXT) absorb_byte(it.text_char);
    else text_ovf = 1'b1;
    if (it.text_last) begin
      r.found       = (best_len != '0);
      r.best_start  = r.found ? best_at : '0;
      r.best_length = r.found ? best_len : '0;
      r.overflow    = text_ovf;
      expected_windows.push_back(r);
      clear_search();
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LENGTH: pat_len_q = data[4:0];
      REG_PATTERN_LOW:    chars_lo  = data;
      REG_PATTERN_HIGH:   chars_hi  = data;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_write <= 1'b0;
  endtask

  task automatic set_pattern(input logic [CFG_W-1:0] len, input logic [63:0] lo,
                             input logic [63:0] hi);
    cfg_put(REG_PATTERN_LENGTH, len);
    cfg_put(REG_PATTERN_LOW, lo);
    cfg_put(REG_PATTERN_HIGH, hi);
    cfg_done();
  endtask

  // drop valid, let every owed window come out, then wait DRAIN_CYCLES more
  // so that a trailing unmarked item has surely landed in the cells
  task automatic settle();
    text_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_item(input in_item_t it);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= it;
    do @(posedge clk); while (text_stall);
    predict_item(it);
  endtask

  task automatic send_text(input text_t t);
    in_item_t it;
    foreach (t[i]) begin
      it.text_char = t[i];
      it.text_last = (i == t.size() - 1);
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------- result side

  // receiver hold-off: a long hold on request, otherwise short random bursts
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // every accepted window against the oldest one owed
  always @(posedge clk) begin : window_check
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_windows.size() == 0) begin
        $error("window with no text pending: found %0d start %0d length %0d overflow %0d",
               result_item.found, result_item.best_start, result_item.best_length,
               result_item.overflow);
        errors++;
      end else begin
        want = expected_windows.pop_front();
        if (result_item.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, result_item.found);
          errors++;
        end
        if (result_item.best_start !== want.best_start) begin
          $error("best_start: expected %0d, got %0d", want.best_start, result_item.best_start);
          errors++;
        end
        if (result_item.best_length !== want.best_length) begin
          $error("best_length: expected %0d, got %0d", want.best_length,
                 result_item.best_length);
          errors++;
        end
        if (result_item.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, result_item.overflow);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    in_item_t it;
    // after reset the pattern is a single zero byte
    send_text('{8'h05, 8'h00});
    settle();
    // pattern "ab": two equal windows, the earliest wins
    set_pattern(2, 64'h6261, 64'h0);
    send_text('{8'h61, 8'h62, 8'h61, 8'h62});
    // a later shorter window replaces a longer one
    send_text('{8'h61, 8'h78, 8'h62, 8'h61, 8'h62});
    // characters out of order: no match, all zero
    send_text('{8'h78, 8'h62, 8'h61});
    settle();
    // length zero with junk above the field acts as length one
    cfg_put(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    cfg_put(REG_PATTERN_LOW, 64'h5555_5555_5555_5580);
    cfg_done();
    send_text('{8'h80});
    settle();
    // length beyond the cell count saturates at sixteen, three bytes cannot match
    set_pattern(31, {8{8'h11}}, {8{8'h11}});
    send_text('{8'h11, 8'h11, 8'h11});
    settle();
    // byte extremes: pattern ff then 00
    set_pattern(2, 64'h00FF, 64'h0);
    send_text('{8'h00, 8'hFF, 8'h00});
    settle();
    // pattern changed in the middle of a text: cells are kept
    set_pattern(2, 64'h6261, 64'h0);
    it.text_char = 8'h61;
    it.text_last = 1'b0;
    send_item(it);
    settle();
    cfg_put(REG_PATTERN_LOW, 64'h6361);
    cfg_done();
    send_text('{8'h63});
    settle();
    // a write to the unmapped index leaves the pattern alone
    cfg_put(REG_UNMAPPED, {CFG_W{1'b1}});
    cfg_done();
    send_text('{8'h61, 8'h63});
    settle();
  endtask

  // texts at and past the length limit, with windows at the extremes
  task automatic test_long_texts();
    in_item_t it;
    logic [7:0] fill;
    gap_pct   = 0;
    stall_pct = 0;
    // 'A' first and 'B' at the last counted position: widest window, then overflow
    set_pattern(2, 64'h4241, 64'h0);
    for (int i = 0; i < MAX_TEXT + 2; i++) begin
      do fill = 8'($urandom_range(0, 255)); while (fill == 8'h41 || fill == 8'h42);
      if (i == 0) it.text_char = 8'h41;
      else if (i == MAX_TEXT - 1) it.text_char = 8'h42;
      else it.text_char = fill;
      it.text_last = (i == MAX_TEXT + 1);
      send_item(it);
    end
    settle();
    // exactly the limit, single match on the final byte: no overflow
    set_pattern(1, 64'h5A, {$urandom(), $urandom()});
    for (int i = 0; i < MAX_TEXT; i++) begin
      do fill = 8'($urandom_range(0, 255)); while (fill == 8'h5A);
      it.text_char = (i == MAX_TEXT - 1) ? 8'h5A : fill;
      it.text_last = (i == MAX_TEXT - 1);
      send_item(it);
    end
    settle();
  endtask

  // receiver holds off for a long stretch while one-byte texts keep coming,
  // so the result side backs up into the text input
  task automatic test_backpressure();
    in_item_t it;
    gap_pct   = 0;
    stall_pct = 0;
    set_pattern(1, 64'h33, 64'h0);
    long_hold_go = 1'b1;
    @(posedge clk);
    for (int i = 0; i < 60; i++) begin
      it.text_char = ($urandom_range(0, 1) == 0) ? 8'h33 : 8'($urandom_range(0, 255));
      it.text_last = 1'b1;
      send_item(it);
    end
    settle();
  endtask

  task automatic pick_noise(input logic [7:0] alpha [4], output logic [7:0] c);
    if ($urandom_range(0, 3) != 0) c = alpha[$urandom_range(0, 3)];
    else c = 8'($urandom_range(0, 255));
  endtask

  // mostly the pattern in order with noise between; some pure noise,
  // some with one pattern character dropped
  task automatic build_text(input logic [7:0] alpha [4], output text_t t);
    int unsigned n;
    int unsigned kind;
    int unsigned skip;
    logic [7:0]  c;
    t = {};
    n = used_len();
    kind = $urandom_range(0, 9);
    if (kind >= 7 && kind < 9) begin
      repeat ($urandom_range(1, 12)) begin
        pick_noise(alpha, c);
        t.push_back(c);
      end
    end else begin
      skip = (kind == 9) ? $urandom_range(0, n - 1) : n;
      for (int unsigned k = 0; k < n; k++) begin
        repeat ($urandom_range(0, 2)) begin
          pick_noise(alpha, c);
          t.push_back(c);
        end
        if (k != skip) t.push_back(char_at(k));
      end
      repeat ($urandom_range(0, 3)) begin
        pick_noise(alpha, c);
        t.push_back(c);
      end
      if (t.size() == 0) begin
        pick_noise(alpha, c);
        t.push_back(c);
      end
    end
  endtask

  task automatic test_random(input int phases);
    logic [7:0]       alpha [4];
    logic [CFG_W-1:0] len_word;
    logic [63:0]      lo;
    logic [63:0]      hi;
    text_t            t;
    int unsigned      sent;
    for (int p = 0; p < phases; p++) begin
      // length cycles through one, full, in between, zero and oversized
      len_word = {$urandom(), $urandom()};
      case (p % 5)
        0: len_word[4:0] = 5'd1;
        1: len_word[4:0] = 5'd16;
        2: len_word[4:0] = 5'($urandom_range(2, 15));
        3: len_word[4:0] = 5'd0;
        default: len_word[4:0] = 5'($urandom_range(17, 31));
      endcase
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      if (p % 4 == 1) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
      end
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = alpha[$urandom_range(0, 3)];
        hi[8*k +: 8] = alpha[$urandom_range(0, 3)];
      end
      set_pattern(len_word, lo, hi);
      // the closing phases run flat out, others draw their own pacing
      if (p >= phases - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_text(alpha, t);
        send_text(t);
        sent += t.size();
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst        = 1'b1;
    text_valid = 1'b0;
    text_item  = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    pat_len_q  = 5'd1;
    chars_lo   = '0;
    chars_hi   = '0;
    clear_search();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_texts();
    test_backpressure();
    test_random(10);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("min_window_subsequence_tb passed");
    end else begin
      $display("min_window_subsequence_tb failed");
    end
    $finish;
  end

endmodule
